// ===== design/two_point_gain_offset_calibrator_unit_assert.svh =====
// assertion macros for the two-point gain and offset calibrator
`ifndef TWO_POINT_GAIN_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH
`define TWO_POINT_GAIN_OFFSET_CALIBRATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TPGOC_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("calibrator check failed");

`define TPGOC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("calibrator check failed");

`else

`define TPGOC_ASSERT_HOLDS(label, cond)

`define TPGOC_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

// ===== design/tpgoc_pkg.sv =====
// shared constants for the two-point gain and offset calibrator
package tpgoc_pkg;

    localparam int DATA_W    = 16;
    localparam int OFS_W     = 14;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int MUL_STEPS = DATA_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] NOMINAL_GAIN_DEF = 16'd1000;
    localparam logic [DATA_W-1:0] GAIN_MIN_RST     = 16'd500;
    localparam logic [DATA_W-1:0] GAIN_MAX_RST     = 16'd2000;
    localparam logic [DATA_W-1:0] OUT_MAX_RST      = 16'd65535;
    localparam logic [DATA_W-1:0] MILLI_SCALE      = 16'd1000;
    localparam int                OFFSET_LIMIT     = 5000;

    localparam logic [OP_W-1:0] OP_CONVERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIT     = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX  = 2'd2;

endpackage

// ===== design/two_point_gain_offset_calibrator_unit.sv =====
// two-point gain and offset calibrator with bit-serial multiplier and divider
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_op, i_pin_mv, first and second points
//  result    out        o_valid / i_ready      o_line_mv, o_fit_accepted, o_cal_valid, ...
//  config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
//  convert: a multiply pass by the gain, a divide pass by the milli scale, then offset add and clamp
//  fit: two multiply and divide passes with gain and offset checks; restore or op 3 goes straight to the result
//  the shift-add multiplier and restoring divider each resolve one bit per cycle
//  one item in flight; a finished result waits in the output register while the next is taken
//  synchronous active-low reset restores registers, gain and offset to defaults
`include "two_point_gain_offset_calibrator_unit_assert.svh"

module two_point_gain_offset_calibrator_unit #(
    parameter logic [tpgoc_pkg::DATA_W-1:0] NOMINAL_GAIN_MILLI = tpgoc_pkg::NOMINAL_GAIN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tpgoc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [tpgoc_pkg::OP_W-1:0]         i_op,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_pin_mv,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_first_line_mv,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_first_pin_mv,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_second_line_mv,
    input  logic [tpgoc_pkg::DATA_W-1:0]       i_second_pin_mv,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [tpgoc_pkg::DATA_W-1:0]       o_line_mv,
    output logic                               o_fit_accepted,
    output logic                               o_cal_valid,
    output logic [tpgoc_pkg::DATA_W-1:0]       o_gain_now,
    output logic signed [tpgoc_pkg::OFS_W-1:0] o_offset_now
);

    import tpgoc_pkg::*;

    localparam int SUM_W = 25;
    localparam int Q_W   = 23;
    localparam logic [CNT_W-1:0]        MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0]        DIV_LAST  = CNT_W'(DIV_STEPS - 1);
    localparam logic signed [SUM_W-1:0] OFS_LIM   = SUM_W'(OFFSET_LIMIT);
    localparam logic signed [OFS_W-1:0] OFS_LIM14 = OFS_W'(OFFSET_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_POST1,
        S_MUL2,
        S_DIV2,
        S_POST2,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [DATA_W-1:0]         r_gain_min;
    logic [DATA_W-1:0]         r_gain_max;
    logic [DATA_W-1:0]         r_out_max;
    logic [DATA_W-1:0]         r_gain;
    logic signed [OFS_W-1:0]   r_offset;
    logic [OP_W-1:0]           r_op;
    logic [DATA_W-1:0]         r_l1;
    logic [DATA_W-1:0]         r_p1;
    logic [DATA_W-1:0]         r_pd;
    logic [CNT_W-1:0]          r_cnt;
    logic [DATA_W-1:0]         r_mcand;
    logic [PROD_W-1:0]         r_mprod;
    logic [PROD_W-1:0]         r_dnum;
    logic [DATA_W-1:0]         r_drem;
    logic [DATA_W-1:0]         r_ddiv;
    logic [DATA_W-1:0]         r_line;
    logic                      r_fit;
    logic                      r_o_valid;
    logic [DATA_W-1:0]         r_o_line;
    logic                      r_o_fit;
    logic                      r_o_cal;
    logic [DATA_W-1:0]         r_o_gain;
    logic signed [OFS_W-1:0]   r_o_offset;

    logic [DATA_W-1:0]         pin_span;
    logic [DATA_W-1:0]         line_span;
    logic                      deltas_ok;
    logic [DATA_W:0]           mul_sum;
    logic [PROD_W-1:0]         n_mprod;
    logic [DATA_W:0]           div_trial;
    logic [DATA_W:0]           div_diff;
    logic                      div_ge;
    logic [DATA_W-1:0]         n_drem;
    logic [PROD_W-1:0]         n_dnum;
    logic signed [SUM_W-1:0]   conv_sum;
    logic [DATA_W-1:0]         conv_line;
    logic                      gain_ok;
    logic signed [SUM_W-1:0]   ofs_diff;
    logic                      ofs_ok;
    logic                      cal_ok;

    assign pin_span  = i_second_pin_mv - i_first_pin_mv;
    assign line_span = i_second_line_mv - i_first_line_mv;
    assign deltas_ok = (i_second_pin_mv > i_first_pin_mv) &&
                       (i_second_line_mv > i_first_line_mv);

    // shift-add multiplier, one multiplier bit per cycle
    assign mul_sum = {1'b0, r_mprod[PROD_W-1:DATA_W]} +
                     {1'b0, (r_mprod[0] ? r_mcand : {DATA_W{1'b0}})};
    assign n_mprod = {mul_sum, r_mprod[DATA_W-1:1]};

    // restoring divider, one quotient bit per cycle
    assign div_trial = {r_drem, r_dnum[PROD_W-1]};
    assign div_diff  = div_trial - {1'b0, r_ddiv};
    assign div_ge    = div_trial >= {1'b0, r_ddiv};
    assign n_drem    = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
    assign n_dnum    = {r_dnum[PROD_W-2:0], div_ge};

    assign conv_sum = $signed({2'b0, r_dnum[Q_W-1:0]}) +
                      $signed({{(SUM_W-OFS_W){r_offset[OFS_W-1]}}, r_offset});

    always_comb begin
        if (conv_sum[SUM_W-1]) begin
            conv_line = '0;
        end else if (conv_sum[SUM_W-2:0] > {{(SUM_W-1-DATA_W){1'b0}}, r_out_max}) begin
            conv_line = r_out_max;
        end else begin
            conv_line = conv_sum[DATA_W-1:0];
        end
    end

    assign gain_ok = (r_dnum[PROD_W-1:DATA_W] == '0) &&
                     (r_dnum[DATA_W-1:0] >= r_gain_min) &&
                     (r_dnum[DATA_W-1:0] <= r_gain_max);

    assign ofs_diff = $signed({{(SUM_W-DATA_W){1'b0}}, r_l1}) -
                      $signed({2'b0, r_dnum[Q_W-1:0]});
    assign ofs_ok   = (ofs_diff > -OFS_LIM) && (ofs_diff < OFS_LIM);

    assign cal_ok = (r_gain >= r_gain_min) && (r_gain <= r_gain_max) &&
                    (r_offset > -OFS_LIM14) && (r_offset < OFS_LIM14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gain_min <= GAIN_MIN_RST;
            r_gain_max <= GAIN_MAX_RST;
            r_out_max  <= OUT_MAX_RST;
            r_gain     <= NOMINAL_GAIN_MILLI;
            r_offset   <= '0;
            r_op       <= OP_CONVERT;
            r_l1       <= '0;
            r_p1       <= '0;
            r_pd       <= '0;
            r_cnt      <= '0;
            r_mcand    <= '0;
            r_mprod    <= '0;
            r_dnum     <= '0;
            r_drem     <= '0;
            r_ddiv     <= '0;
            r_line     <= '0;
            r_fit      <= 1'b0;
            r_o_valid  <= 1'b0;
            r_o_line   <= '0;
            r_o_fit    <= 1'b0;
            r_o_cal    <= 1'b0;
            r_o_gain   <= '0;
            r_o_offset <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_MIN: r_gain_min <= i_cfg_data;
                    CFG_GAIN_MAX: r_gain_max <= i_cfg_data;
                    CFG_OUT_MAX:  r_out_max  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_o_valid && i_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_op;
                        r_line <= '0;
                        r_fit  <= 1'b0;
                        r_cnt  <= '0;
                        r_l1   <= i_first_line_mv;
                        r_p1   <= i_first_pin_mv;
                        r_pd   <= pin_span;
                        priority if (i_op == OP_CONVERT) begin
                            r_mcand <= r_gain;
                            r_mprod <= {{DATA_W{1'b0}}, i_pin_mv};
                            r_state <= S_MUL1;
                        end else if (i_op == OP_FIT) begin
                            if (deltas_ok) begin
                                r_mcand <= MILLI_SCALE;
                                r_mprod <= {{DATA_W{1'b0}}, line_span};
                                r_state <= S_MUL1;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else if (i_op == OP_RESTORE) begin
                            r_gain   <= NOMINAL_GAIN_MILLI;
                            r_offset <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL1: begin
                    r_mprod <= n_mprod;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_drem  <= '0;
                        r_state <= S_DIV1;
                        // fit divides with half the divisor added for rounding
                        if (r_op == OP_FIT) begin
                            r_dnum <= n_mprod + {{(DATA_W+1){1'b0}}, r_pd[DATA_W-1:1]};
                            r_ddiv <= r_pd;
                        end else begin
                            r_dnum <= n_mprod;
                            r_ddiv <= MILLI_SCALE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV1: begin
                    r_dnum <= n_dnum;
                    r_drem <= n_drem;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_POST1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_POST1: begin
                    if (r_op == OP_FIT) begin
                        if (gain_ok) begin
                            r_mcand <= r_dnum[DATA_W-1:0];
                            r_mprod <= {{DATA_W{1'b0}}, r_p1};
                            r_state <= S_MUL2;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_line  <= conv_line;
                        r_state <= S_DONE;
                    end
                end
                S_MUL2: begin
                    r_mprod <= n_mprod;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_drem  <= '0;
                        r_dnum  <= n_mprod;
                        r_ddiv  <= MILLI_SCALE;
                        r_state <= S_DIV2;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV2: begin
                    r_dnum <= n_dnum;
                    r_drem <= n_drem;
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_POST2;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_POST2: begin
                    if (ofs_ok) begin
                        r_gain   <= r_mcand;
                        r_offset <= ofs_diff[OFS_W-1:0];
                        r_fit    <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_line   <= r_line;
                        r_o_fit    <= r_fit;
                        r_o_cal    <= cal_ok;
                        r_o_gain   <= r_gain;
                        r_o_offset <= r_offset;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_line_mv      = r_o_line;
    assign o_fit_accepted = r_o_fit;
    assign o_cal_valid    = r_o_cal;
    assign o_gain_now     = r_o_gain;
    assign o_offset_now   = r_o_offset;

    `TPGOC_ASSERT_HOLDS(a_offset_in_range, (r_offset > -OFS_LIM14) && (r_offset < OFS_LIM14))
    `TPGOC_ASSERT_IMPLY(a_div_nonzero, (r_state == S_DIV1) || (r_state == S_DIV2), r_ddiv != '0)
    `TPGOC_ASSERT_IMPLY(a_mul_count, (r_state == S_MUL1) || (r_state == S_MUL2), r_cnt <= MUL_LAST)
    `TPGOC_ASSERT_IMPLY(a_fit_result, r_o_valid && r_o_fit, r_o_cal && (r_o_line == '0))

endmodule
